// ----- rtl/core/conic_orbit_point_generator_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Conic orbit point generator assertion macros
// Shared concurrent assertion helpers, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef CONIC_ORBIT_POINT_GENERATOR_UNIT_MACROS_SVH
`define CONIC_ORBIT_POINT_GENERATOR_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define COPG_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("copg check failed");
// The consequent must hold in the cycle after the antecedent.
`define COPG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("copg check failed");
`else
`define COPG_ASSERT_SAME(lbl, ante, cons)
`define COPG_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/core/copg_pkg.sv -----
// ----------------------------------------------------------------------------
// Conic orbit point generator package
// Widths, constants, register indexes and shared types of the block.
// ----------------------------------------------------------------------------
package copg_pkg;

    // Field widths.
    localparam int ANGLE_W    = 16;
    localparam int STEP_W     = 15;
    localparam int INDEX_W    = 10;
    localparam int AXIS_W     = 32;
    localparam int ECC_W      = 20;
    localparam int POINT_W    = 48;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // Datapath widths.
    localparam int CW     = 34;
    localparam int Q16_W  = 18;
    localparam int NUM_W  = 57;
    localparam int DEN_W  = 25;
    localparam int QMAG_W = 56;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_SEMI_MAJOR_AXIS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ECCENTRICITY    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRUE_ANOMALY    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_ANGLE      = 8'd3;

    // Reset value of the step angle.
    localparam logic [STEP_W-1:0] STEP_RESET = 15'd182;

    // Angle constants; half a turn is 32768 in angle units.
    localparam int PI_TURN = 32768;
    localparam logic signed [ANGLE_W-1:0] ANGLE_MINUS_PI = 16'sh8000;

    // Rotator constants, 2^32 per turn for the angle, Q2.30 for the vector.
    localparam logic signed [CW-1:0] CORDIC_K  = 34'sd652032874;
    localparam logic signed [CW-1:0] HALF_PI_Z = 34'sd1073741824;
    localparam logic signed [CW-1:0] PI_Z      = 34'sd2147483648;
    localparam logic signed [CW-1:0] ROUND_Q16 = 34'sd8192;
    localparam logic signed [CW-1:0] LIMIT_Q16 = 34'sd65536;
    localparam int ATAN_ENTRIES = 24;
    localparam logic signed [CW-1:0] ATAN_TAB [ATAN_ENTRIES] = '{
        34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
        34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
        34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
        34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
        34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
        34'sd652,       34'sd326,       34'sd163,       34'sd81
    };

    // Radius and scale constants.
    localparam logic signed [Q16_W-1:0] Q16_ONE    = 18'sd65536;
    localparam logic signed [DEN_W-1:0] DEN_ONE    = 25'sd65536;
    localparam logic signed [POINT_W-1:0] RADIUS_MAX = 48'sh7FFF_FFFF_FFFF;

    // Configuration register set.
    typedef struct packed {
        logic signed [AXIS_W-1:0]  axis;
        logic        [ECC_W-1:0]   ecc;
        logic signed [ANGLE_W-1:0] anomaly;
        logic        [STEP_W-1:0]  step;
    } t_cfg;

    // Classified item passed from the front to the back.
    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle;
        logic                      past_end;
    } t_item;

    // Side information carried alongside the radius division.
    typedef struct packed {
        logic                    behind;
        logic                    past_end;
        logic signed [Q16_W-1:0] c16;
        logic signed [Q16_W-1:0] s16;
    } t_geo;

endpackage

// ----- rtl/core/conic_orbit_point_generator_unit.sv -----
// ----------------------------------------------------------------------------
// Conic orbit point generator
// Computes points of a conic orbit in focal polar form from step indexes.
// ----------------------------------------------------------------------------
// One step index enters per clock and one point leaves per clock while the
// output is not stalled. A point passes through the queue, the rotator, the
// denominator register, the radius divider (one quotient bit per stage over a
// 56-bit dividend), the coordinate products and the output register. Points
// leave in index order, and a stalled output holds the whole back end while
// the four-entry queue keeps taking indexes.
// ----------------------------------------------------------------------------
module conic_orbit_point_generator_unit #(
    parameter int MAX_STEPS         = 1024,
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [copg_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [copg_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [copg_pkg::INDEX_W-1:0]         i_step_index,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [copg_pkg::POINT_W-1:0]  o_point_x,
    output logic signed [copg_pkg::POINT_W-1:0]  o_point_y,
    output logic                                 o_past_end,
    output logic                                 o_behind_focus
);
    import copg_pkg::*;

    t_cfg  r_cfg;
    t_item w_front_item;
    t_item w_queue_item;
    logic  w_full;
    logic  w_empty;
    logic  w_pop;

    // Configuration registers; unknown indexes are ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.axis    <= '0;
            r_cfg.ecc     <= '0;
            r_cfg.anomaly <= '0;
            r_cfg.step    <= STEP_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SEMI_MAJOR_AXIS: r_cfg.axis    <= i_cfg_data[AXIS_W-1:0];
                REG_ECCENTRICITY:    r_cfg.ecc     <= i_cfg_data[ECC_W-1:0];
                REG_TRUE_ANOMALY:    r_cfg.anomaly <= i_cfg_data[ANGLE_W-1:0];
                REG_STEP_ANGLE:      r_cfg.step    <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    copg_front #(
        .MAX_STEPS (MAX_STEPS)
    ) u_front (
        .i_cfg        (r_cfg),
        .i_step_index (i_step_index),
        .o_item       (w_front_item)
    );

    // An index is transferred whenever the queue has room.
    assign o_in_ready = !w_full;

    copg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid && !w_full),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_item  (w_queue_item),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    copg_back #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_item         (w_queue_item),
        .i_item_valid   (!w_empty),
        .o_pop          (w_pop),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_point_x      (o_point_x),
        .o_point_y      (o_point_y),
        .o_past_end     (o_past_end),
        .o_behind_focus (o_behind_focus)
    );

endmodule

// ----- rtl/core/copg_front.sv -----
// ----------------------------------------------------------------------------
// Conic orbit point generator front end
// Forms the angle of a step index and marks points past the end of the path.
// ----------------------------------------------------------------------------
module copg_front #(
    parameter int MAX_STEPS = 1024
) (
    input  copg_pkg::t_cfg              i_cfg,
    input  logic [copg_pkg::INDEX_W-1:0] i_step_index,
    output copg_pkg::t_item             o_item
);
    import copg_pkg::*;

    localparam int PROD_W = INDEX_W + STEP_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int IDXC_W = 17;

    logic        [PROD_W-1:0]  w_prod;
    logic signed [ANGLE_W-1:0] w_start;
    logic signed [SUM_W-1:0]   w_angle;
    logic                      w_over_idx;

    // Unwrapped angle: start plus index times step.
    assign w_prod  = PROD_W'(i_step_index) * PROD_W'(i_cfg.step);
    assign w_start = (i_cfg.axis > 0) ? ANGLE_MINUS_PI : i_cfg.anomaly;
    assign w_angle = SUM_W'(w_start) + $signed({2'b00, w_prod});

    // A point is past the end at half a turn or more, or at an index not below the step count.
    assign w_over_idx      = IDXC_W'(i_step_index) >= IDXC_W'(MAX_STEPS);
    assign o_item.past_end = w_over_idx || (w_angle >= $signed(SUM_W'(PI_TURN)));
    assign o_item.angle    = w_angle[ANGLE_W-1:0];

endmodule

// ----- rtl/core/copg_queue.sv -----
// ----------------------------------------------------------------------------
// Conic orbit point generator item queue
// Short queue that decouples the front end from the computing back end.
// ----------------------------------------------------------------------------
`include "conic_orbit_point_generator_unit_macros.svh"
module copg_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  copg_pkg::t_item i_item,
    input  logic            i_pop,
    output copg_pkg::t_item o_item,
    output logic            o_full,
    output logic            o_empty
);
    import copg_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_count;
    logic [QPTR_W:0]   n_count;

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // Occupancy update.
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // Pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= n_count;
        end
    end

    assign o_item  = r_mem[r_rd];
    assign o_full  = r_count == (QPTR_W+1)'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;

    `COPG_ASSERT_SAME(a_count_bound, 1'b1, r_count <= (QPTR_W+1)'(QUEUE_DEPTH))
    `COPG_ASSERT_SAME(a_no_pop_empty, i_pop, r_count != '0)
    `COPG_ASSERT_NEXT(a_push_grows, i_push && !i_pop, r_count == $past(r_count) + 1'b1)

endmodule

// ----- rtl/core/copg_cordic.sv -----
// ----------------------------------------------------------------------------
// Conic orbit point generator rotator
// Pipelined CORDIC giving cosine and sine in Q2.30, one stage per iteration.
// ----------------------------------------------------------------------------
module copg_cordic #(
    parameter int ITER  = 16,
    parameter int TAG_W = 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic signed [copg_pkg::ANGLE_W-1:0] i_angle,
    input  logic [TAG_W-1:0]                  i_tag,
    output logic                              o_valid,
    output logic signed [copg_pkg::CW-1:0]    o_cos,
    output logic signed [copg_pkg::CW-1:0]    o_sin,
    output logic [TAG_W-1:0]                  o_tag
);
    import copg_pkg::*;

    logic signed [CW-1:0] r_x   [ITER+1];
    logic signed [CW-1:0] r_y   [ITER+1];
    logic signed [CW-1:0] r_z   [ITER+1];
    logic                 r_neg [ITER+1];
    logic [TAG_W-1:0]     r_tag [ITER+1];
    logic                 r_v   [ITER+1];
    logic signed [CW-1:0] w_z;

    // Fold the angle into the right half plane.
    assign w_z = $signed({{(CW-ANGLE_W-16){i_angle[ANGLE_W-1]}}, i_angle, 16'h0000});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= CORDIC_K;
            r_y[0]   <= '0;
            r_tag[0] <= i_tag;
            if (w_z > HALF_PI_Z) begin
                r_z[0]   <= w_z - PI_Z;
                r_neg[0] <= 1'b1;
            end else if (w_z < -HALF_PI_Z) begin
                r_z[0]   <= w_z + PI_Z;
                r_neg[0] <= 1'b1;
            end else begin
                r_z[0]   <= w_z;
                r_neg[0] <= 1'b0;
            end
        end
    end

    // Rotation stages.
    for (genvar k = 0; k < ITER; k++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[k+1] <= r_neg[k];
                r_tag[k+1] <= r_tag[k];
                if (r_z[k] >= 0) begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - ATAN_TAB[k];
                end else begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + ATAN_TAB[k];
                end
            end
        end
    end

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= ITER; k++) begin
                r_v[k] <= 1'b0;
            end
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 0; k < ITER; k++) begin
                r_v[k+1] <= r_v[k];
            end
            o_valid <= r_v[ITER];
        end
    end

    // Undo the half-turn fold.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cos <= r_neg[ITER] ? -r_x[ITER] : r_x[ITER];
            o_sin <= r_neg[ITER] ? -r_y[ITER] : r_y[ITER];
            o_tag <= r_tag[ITER];
        end
    end

endmodule

// ----- rtl/core/copg_div.sv -----
// ----------------------------------------------------------------------------
// Conic orbit point generator radius divider
// Pipelined restoring divider, one quotient bit per stage, saturating result.
// ----------------------------------------------------------------------------
module copg_div #(
    parameter int TAG_W = 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [copg_pkg::NUM_W-1:0]   i_num,
    input  logic signed [copg_pkg::DEN_W-1:0]   i_den,
    input  logic [TAG_W-1:0]                    i_tag,
    output logic                                o_valid,
    output logic signed [copg_pkg::POINT_W-1:0] o_q,
    output logic [TAG_W-1:0]                    o_tag
);
    import copg_pkg::*;

    localparam int RW = DEN_W + 1;

    logic [RW-1:0]     r_rem   [QMAG_W+1];
    logic [QMAG_W-1:0] r_qd    [QMAG_W+1];
    logic [DEN_W-1:0]  r_d     [QMAG_W+1];
    logic              r_neg   [QMAG_W+1];
    logic              r_dz    [QMAG_W+1];
    logic              r_nsign [QMAG_W+1];
    logic              r_nnz   [QMAG_W+1];
    logic [TAG_W-1:0]  r_tag   [QMAG_W+1];
    logic              r_v     [QMAG_W+1];
    logic [NUM_W-1:0]  w_nabs;
    logic [DEN_W-1:0]  w_dabs;
    logic [QMAG_W-1:0] w_qmag;
    logic signed [POINT_W-1:0] w_qsat;

    // Operand magnitudes and signs.
    assign w_nabs = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
    assign w_dabs = i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]   <= '0;
            r_qd[0]    <= w_nabs[QMAG_W-1:0];
            r_d[0]     <= w_dabs;
            r_neg[0]   <= i_num[NUM_W-1] ^ i_den[DEN_W-1];
            r_dz[0]    <= i_den == '0;
            r_nsign[0] <= i_num[NUM_W-1];
            r_nnz[0]   <= i_num != '0;
            r_tag[0]   <= i_tag;
        end
    end

    // Restoring steps, most significant dividend bit first.
    for (genvar k = 0; k < QMAG_W; k++) begin : g_step
        logic [RW-1:0] w_trial;
        logic          w_take;
        assign w_trial = {r_rem[k][RW-2:0], r_qd[k][QMAG_W-1]};
        assign w_take  = w_trial >= {1'b0, r_d[k]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]   <= w_take ? (w_trial - {1'b0, r_d[k]}) : w_trial;
                r_qd[k+1]    <= {r_qd[k][QMAG_W-2:0], w_take};
                r_d[k+1]     <= r_d[k];
                r_neg[k+1]   <= r_neg[k];
                r_dz[k+1]    <= r_dz[k];
                r_nsign[k+1] <= r_nsign[k];
                r_nnz[k+1]   <= r_nnz[k];
                r_tag[k+1]   <= r_tag[k];
            end
        end
    end

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QMAG_W; k++) begin
                r_v[k] <= 1'b0;
            end
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 0; k < QMAG_W; k++) begin
                r_v[k+1] <= r_v[k];
            end
            o_valid <= r_v[QMAG_W];
        end
    end

    // Saturate, restore the sign and handle a zero denominator.
    assign w_qmag = r_qd[QMAG_W];
    assign w_qsat = (w_qmag[QMAG_W-1:POINT_W-1] != '0) ? RADIUS_MAX
                  : $signed({1'b0, w_qmag[POINT_W-2:0]});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_tag <= r_tag[QMAG_W];
            if (r_dz[QMAG_W]) begin
                if (!r_nnz[QMAG_W]) begin
                    o_q <= '0;
                end else begin
                    o_q <= r_nsign[QMAG_W] ? -RADIUS_MAX : RADIUS_MAX;
                end
            end else begin
                o_q <= r_neg[QMAG_W] ? -w_qsat : w_qsat;
            end
        end
    end

endmodule

// ----- rtl/core/copg_back.sv -----
// ----------------------------------------------------------------------------
// Conic orbit point generator back end
// Rotator, denominator, radius division and coordinate scaling to the output.
// ----------------------------------------------------------------------------
`include "conic_orbit_point_generator_unit_macros.svh"
module copg_back #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  copg_pkg::t_cfg                      i_cfg,
    input  copg_pkg::t_item                     i_item,
    input  logic                                i_item_valid,
    output logic                                o_pop,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic signed [copg_pkg::POINT_W-1:0] o_point_x,
    output logic signed [copg_pkg::POINT_W-1:0] o_point_y,
    output logic                                o_past_end,
    output logic                                o_behind_focus
);
    import copg_pkg::*;

    localparam int EE_W  = 2 * ECC_W;
    localparam int EC_W  = CW + ECC_W + 1;
    localparam int HALF  = POINT_W / 2;
    localparam int PLO_W = HALF + 1 + Q16_W;
    localparam int PHI_W = HALF + Q16_W;
    localparam int SUM_W = POINT_W + Q16_W + 1;
    localparam int GEO_W = $bits(t_geo);

    function automatic logic signed [Q16_W-1:0] f_to_q16(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        r = (v + ROUND_Q16) >>> 14;
        if (r > LIMIT_Q16) begin
            return Q16_ONE;
        end else if (r < -LIMIT_Q16) begin
            return -Q16_ONE;
        end
        return r[Q16_W-1:0];
    endfunction

    logic                  w_en;
    logic                  w_cv;
    logic signed [CW-1:0]  w_cos;
    logic signed [CW-1:0]  w_sin;
    logic                  w_cpast;
    logic [EE_W-1:0]       r_ee;
    logic signed [DEN_W-1:0] r_ome;
    logic signed [NUM_W-1:0] r_num;
    logic                  r_d1_v;
    logic                  r_d1_past;
    logic signed [Q16_W-1:0] r_c16;
    logic signed [Q16_W-1:0] r_s16;
    logic signed [EC_W-1:0]  r_ecp;
    logic signed [DEN_W-1:0] w_den;
    t_geo                  w_geo_in;
    logic                  w_qv;
    logic signed [POINT_W-1:0] w_q;
    logic [GEO_W-1:0]      w_qtag;
    t_geo                  w_geo;
    logic                  r_m1_v;
    t_geo                  r_m1_geo;
    logic signed [PLO_W-1:0] r_pxl;
    logic signed [PHI_W-1:0] r_pxh;
    logic signed [PLO_W-1:0] r_pyl;
    logic signed [PHI_W-1:0] r_pyh;
    logic signed [SUM_W-1:0] w_sx;
    logic signed [SUM_W-1:0] w_sy;

    // The whole pipeline advances unless a finished point waits.
    assign w_en  = !o_out_valid || i_out_ready;
    assign o_pop = w_en && i_item_valid;

    // Numerator a(1-e^2); it follows the configuration registers.
    always_ff @(posedge i_clk) begin
        r_ee  <= EE_W'(i_cfg.ecc) * EE_W'(i_cfg.ecc);
        r_ome <= DEN_ONE - $signed({1'b0, r_ee[EE_W-1:16]});
        r_num <= NUM_W'(i_cfg.axis) * NUM_W'(r_ome);
    end

    copg_cordic #(
        .ITER  (CORDIC_ITERATIONS),
        .TAG_W (1)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (o_pop),
        .i_angle (i_item.angle),
        .i_tag   (i_item.past_end),
        .o_valid (w_cv),
        .o_cos   (w_cos),
        .o_sin   (w_sin),
        .o_tag   (w_cpast)
    );

    // Rounded Q16 cosine and sine, and the e*cos product.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d1_past <= w_cpast;
            r_c16     <= f_to_q16(w_cos);
            r_s16     <= f_to_q16(w_sin);
            r_ecp     <= EC_W'($signed({1'b0, i_cfg.ecc})) * EC_W'(w_cos);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1_v <= 1'b0;
        end else if (w_en) begin
            r_d1_v <= w_cv;
        end
    end

    // Denominator 1 + e*cos in Q16.
    assign w_den             = DEN_ONE + $signed(r_ecp[EC_W-1:30]);
    assign w_geo_in.behind   = w_den <= 0;
    assign w_geo_in.past_end = r_d1_past;
    assign w_geo_in.c16      = r_c16;
    assign w_geo_in.s16      = r_s16;

    copg_div #(
        .TAG_W (GEO_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_d1_v),
        .i_num   (r_num),
        .i_den   (w_den),
        .i_tag   (w_geo_in),
        .o_valid (w_qv),
        .o_q     (w_q),
        .o_tag   (w_qtag)
    );

    assign w_geo = w_qtag;

    // Radius times cosine and sine, split into two partial products each.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1_geo <= w_geo;
            r_pxl    <= $signed({1'b0, w_q[HALF-1:0]}) * w_geo.c16;
            r_pxh    <= $signed(w_q[POINT_W-1:HALF]) * w_geo.c16;
            r_pyl    <= $signed({1'b0, w_q[HALF-1:0]}) * w_geo.s16;
            r_pyh    <= $signed(w_q[POINT_W-1:HALF]) * w_geo.s16;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v      <= 1'b0;
            o_out_valid <= 1'b0;
        end else if (w_en) begin
            r_m1_v      <= w_qv;
            o_out_valid <= r_m1_v;
        end
    end

    // Sum the partial products and drop the 16 fraction bits of the Q16 cosine and sine.
    assign w_sx = (SUM_W'(r_pxh) <<< HALF) + SUM_W'(r_pxl);
    assign w_sy = (SUM_W'(r_pyh) <<< HALF) + SUM_W'(r_pyl);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_m1_geo.past_end) begin
                o_point_x      <= '0;
                o_point_y      <= '0;
                o_past_end     <= 1'b1;
                o_behind_focus <= 1'b0;
            end else begin
                o_point_x      <= w_sx[POINT_W+15:16];
                o_point_y      <= w_sy[POINT_W+15:16];
                o_past_end     <= 1'b0;
                o_behind_focus <= r_m1_geo.behind;
            end
        end
    end

    `COPG_ASSERT_SAME(a_end_no_behind, o_out_valid && o_past_end, !o_behind_focus)
    `COPG_ASSERT_SAME(a_end_zero_point, o_out_valid && o_past_end, (o_point_x | o_point_y) == '0)
    `COPG_ASSERT_SAME(a_pop_has_item, o_pop, i_item_valid)
    `COPG_ASSERT_NEXT(a_out_held, o_out_valid && !i_out_ready, o_out_valid && $stable(o_point_x))

endmodule

// ----- tb/copg_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Conic orbit point checker
// Watches the index, point and register channels, works out each expected
// point from its own fixed-point model and compares the points field by field.
// ----------------------------------------------------------------------------
module copg_checker
    import copg_pkg::*;
#(
    parameter int MAX_STEPS         = 1024,
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic [INDEX_W-1:0]           i_step_index,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic signed [POINT_W-1:0]    i_point_x,
    input  logic signed [POINT_W-1:0]    i_point_y,
    input  logic                         i_past_end,
    input  logic                         i_behind_focus,
    output int                           o_errors,
    output int                           o_pending,
    output int                           o_points,
    output int                           o_behind_seen,
    output int                           o_past_seen
);

    typedef struct {
        logic signed [POINT_W-1:0] x;
        logic signed [POINT_W-1:0] y;
        logic                      past_end;
        logic                      behind;
    } t_point;

    t_point expected_points[$];

    // Shadow copy of the register set.
    logic signed [AXIS_W-1:0]  axis_r;
    logic        [ECC_W-1:0]   ecc_r;
    logic signed [ANGLE_W-1:0] anomaly_r;
    logic        [STEP_W-1:0]  step_r;

    // Arithmetic shift right with floor, on 64-bit values.
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_to_q16(longint v30);
        longint r;
        r = floor_shift(v30 + 8192, 14);
        if (r > 65536) r = 65536;
        if (r < -65536) r = -65536;
        return r;
    endfunction

    // Expected point for one step index under the current registers.
    function automatic t_point orbit_point(logic [INDEX_W-1:0] idx_in);
        t_point p;
        longint idx, a, e, start, ang, z, cx, cy, nx, c16, s16;
        longint ome, num, den, q;
        bit flip;
        idx = idx_in;
        a = axis_r;
        e = ecc_r;
        start = (a > 0) ? -PI_TURN : longint'(anomaly_r);
        ang = start + idx * longint'(step_r);
        p = '{x: '0, y: '0, past_end: 1'b0, behind: 1'b0};
        if (ang >= PI_TURN || idx >= MAX_STEPS) begin
            p.past_end = 1'b1;
            return p;
        end
        z = ang * 65536;
        cx = 652032874;
        cy = 0;
        flip = 0;
        if (z > (64'sd1 <<< 30)) begin
            z -= (64'sd1 <<< 31);
            flip = 1;
        end else if (z < -(64'sd1 <<< 30)) begin
            z += (64'sd1 <<< 31);
            flip = 1;
        end
        for (int i = 0; i < CORDIC_ITERATIONS && i < ATAN_ENTRIES; i++) begin
            if (z >= 0) begin
                nx = cx - floor_shift(cy, i);
                cy = cy + floor_shift(cx, i);
                z -= longint'(ATAN_TAB[i]);
            end else begin
                nx = cx + floor_shift(cy, i);
                cy = cy - floor_shift(cx, i);
                z += longint'(ATAN_TAB[i]);
            end
            cx = nx;
        end
        if (flip) begin
            cx = -cx;
            cy = -cy;
        end
        c16 = round_to_q16(cx);
        s16 = round_to_q16(cy);
        ome = 65536 - floor_shift(e * e, 16);
        num = a * ome;
        den = 65536 + floor_shift(e * cx, 30);
        p.behind = (den <= 0);
        if (den == 0) begin
            q = (num > 0) ? longint'(RADIUS_MAX) : (num < 0 ? -longint'(RADIUS_MAX) : 0);
        end else begin
            q = num / den;
            if (q > longint'(RADIUS_MAX)) q = RADIUS_MAX;
            if (q < -longint'(RADIUS_MAX)) q = -longint'(RADIUS_MAX);
        end
        p.x = POINT_W'(floor_shift(q * c16, 16));
        p.y = POINT_W'(floor_shift(q * s16, 16));
        return p;
    endfunction

    assign o_pending = expected_points.size();

    // Register writes, index transfers and point transfers.
    always @(posedge i_clk) begin
        t_point want;
        if (!i_rst_n) begin
            axis_r    <= '0;
            ecc_r     <= '0;
            anomaly_r <= '0;
            step_r    <= STEP_RESET;
            o_errors  <= 0;
            o_points  <= 0;
            o_behind_seen <= 0;
            o_past_seen   <= 0;
            expected_points.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_SEMI_MAJOR_AXIS: axis_r    <= i_cfg_data[AXIS_W-1:0];
                    REG_ECCENTRICITY:    ecc_r     <= i_cfg_data[ECC_W-1:0];
                    REG_TRUE_ANOMALY:    anomaly_r <= i_cfg_data[ANGLE_W-1:0];
                    REG_STEP_ANGLE:      step_r    <= i_cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                expected_points = {expected_points, orbit_point(i_step_index)};
            if (i_out_valid && i_out_ready) begin
                o_points <= o_points + 1;
                if (i_behind_focus) o_behind_seen <= o_behind_seen + 1;
                if (i_past_end) o_past_seen <= o_past_seen + 1;
                if (expected_points.size() == 0) begin
                    $display("%0t: point with none expected: x=%0d y=%0d", $time,
                             i_point_x, i_point_y);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_points.pop_front();
                    if (want.x !== i_point_x || want.y !== i_point_y ||
                        want.past_end !== i_past_end || want.behind !== i_behind_focus) begin
                        $display("%0t: point mismatch: expected x=%0d y=%0d end=%0b behind=%0b",
                                 $time, want.x, want.y, want.past_end, want.behind);
                        $display("%0t:                 actual   x=%0d y=%0d end=%0b behind=%0b",
                                 $time, i_point_x, i_point_y, i_past_end, i_behind_focus);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Conic orbit point generator testbench
// Drives register settings and step indexes with random gaps and output
// stalls, and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module tb;
    import copg_pkg::*;

    localparam int LATENCY     = 16 + 63;
    localparam int CYCLE_LIMIT = 1_000_000;

    // A register index that the block does not decode.
    localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN = 8'd200;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [CFG_DATA_W-1:0]     i_cfg_data;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic [INDEX_W-1:0]        i_step_index;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic signed [POINT_W-1:0] o_point_x;
    logic signed [POINT_W-1:0] o_point_y;
    logic                      o_past_end;
    logic                      o_behind_focus;

    int errors, pending, points, behind_seen, past_seen;
    int cycles;
    bit stimulus_done;

    conic_orbit_point_generator_unit DUT (.*);

    copg_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index,
        .i_cfg_data, .i_in_valid, .i_in_ready(o_in_ready), .i_step_index,
        .i_out_valid(o_out_valid), .i_out_ready, .i_point_x(o_point_x),
        .i_point_y(o_point_y), .i_past_end(o_past_end), .i_behind_focus(o_behind_focus),
        .o_errors(errors), .o_pending(pending), .o_points(points),
        .o_behind_seen(behind_seen), .o_past_seen(past_seen)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Gap length: mostly none or short, now and then long.
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Output stalls, with stretches of none at all.
    initial begin
        int hold;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 199) == 0) begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(100, 300)) @(negedge i_clk);
            end
            hold = gap_length();
            if (hold > 0) begin
                i_out_ready <= 1'b0;
                repeat (hold) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    // One register write transfer; the caller drops valid when done.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_orbit(logic [31:0] axis, logic [19:0] ecc, logic [15:0] anom,
                             logic [14:0] step);
        write_reg(REG_SEMI_MAJOR_AXIS, axis);
        write_reg(REG_ECCENTRICITY, ecc);
        write_reg(REG_TRUE_ANOMALY, anom);
        write_reg(REG_STEP_ANGLE, step);
        i_cfg_valid <= 1'b0;
    endtask

    // One index transfer, after a random gap; valid stays up for a following
    // transfer and is dropped by the next gap or by the drain.
    task automatic send_index(logic [INDEX_W-1:0] idx);
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_step_index <= idx;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Wait until every expected point has come back and the pipe is empty.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
    endtask

    // Random index, biased to small values so that most points are on the path.
    function automatic logic [INDEX_W-1:0] pick_index();
        if ($urandom_range(0, 3) == 0) return INDEX_W'($urandom_range(0, 1023));
        return INDEX_W'($urandom_range(0, 40));
    endfunction

    // Stimulus.
    initial begin
        int ecc_pick;
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_step_index = '0;
        stimulus_done = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: zero axis, so every radius is zero.
        send_index(10'd0);
        send_index(10'd1023);
        send_index(10'd180);
        drain();

        // Circle, ellipse, parabola, hyperbola and an unknown register.
        set_orbit(32'd25600, 20'd0, 16'd0, 15'd4096);
        for (int k = 0; k < 9; k++) send_index(INDEX_W'(k));
        drain();
        set_orbit(32'h7FFF_FFFF, 20'd32768, 16'd0, 15'd1);
        send_index(10'd0);
        send_index(10'd1023);
        drain();
        write_reg(REG_UNKNOWN, 32'hFFFF_FFFF);
        set_orbit(-32'd5000, 20'd65536, 16'h8000, 15'd16384);
        send_index(10'd0);
        send_index(10'd1);
        send_index(10'd2);
        send_index(10'd3);
        drain();
        set_orbit(32'h8000_0000, 20'hFFFFF, 16'h7FFF, 15'h7FFF);
        send_index(10'd0);
        send_index(10'd1);
        drain();
        set_orbit(-32'd1000, 20'd131072, 16'hC000, 15'd0);
        send_index(10'd0);
        send_index(10'd1023);
        drain();

        // Random phases of settings, each followed by a run of indexes.
        for (int ph = 0; ph < 22; ph++) begin
            ecc_pick = $urandom_range(0, 4);
            set_orbit($urandom_range(0, 3) == 0 ? $urandom() :
                          32'($signed($urandom_range(0, 400000)) - 200000),
                      ecc_pick == 0 ? 20'd0 : ecc_pick == 1 ? 20'hFFFFF :
                          ecc_pick == 2 ? 20'($urandom_range(0, 65535)) :
                          20'($urandom()),
                      16'($urandom()),
                      ph % 7 == 0 ? 15'($urandom()) : 15'($urandom_range(1, 2000)));
            repeat (25) send_index(pick_index());
            drain();
        end
        stimulus_done = 1;
    end

    // Cycle counter and verdict.
    initial begin
        cycles = 0;
        while (!stimulus_done && cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        if (!stimulus_done) begin
            $display("tb: failure");
            $finish;
        end else begin
            $display("Covered %0d points over several orbit settings.", points);
            $display("%0d were behind the focus and %0d past the end.",
                     behind_seen, past_seen);
            if (errors == 0) begin
                $display("tb: success");
            end else begin
                $display("tb: failure");
            end
            $finish;
        end
    end

endmodule

// ----- conic_orbit_point_generator_unit.f -----
+incdir+rtl/core
rtl/core/copg_pkg.sv
rtl/core/copg_front.sv
rtl/core/copg_queue.sv
rtl/core/copg_cordic.sv
rtl/core/copg_div.sv
rtl/core/copg_back.sv
rtl/core/conic_orbit_point_generator_unit.sv
tb/copg_checker.sv
tb/tb.sv
